/* hw/rtl/maepc_pkg.sv */
// Package: shared types, constants and register indexes of the position controller
package maepc_pkg;

  localparam int AXES_DEF       = 4;
  localparam int COUNT_BITS_DEF = 16;
  localparam int WRAP_LIMIT_DEF = 30000;
  localparam int MAX_MM_DEF     = 600;

  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2,
    MODE_READ = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_HOMING = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PPMM     = 3'd0,
    REG_DEADBAND = 3'd1,
    REG_REVERSE  = 3'd2,
    REG_HOME_DIR = 3'd3,
    REG_GRACE    = 3'd4,
    REG_STALL_T  = 3'd5,
    REG_MAX_T    = 3'd6,
    REG_STALL_P  = 3'd7
  } reg_idx_t;

  // Settings shared by every lane
  typedef struct packed {
    logic [15:0]      ppmm;
    logic [9:0]       deadband;
    logic [CNT_W-1:0] grace;
    logic [CNT_W-1:0] stall_t;
    logic [CNT_W-1:0] max_t;
    logic [7:0]       stall_p;
  } lane_cfg_t;

  // Per-lane command decoded from one item
  typedef struct packed {
    logic        tick;
    logic        move;
    logic        home;
    logic [9:0]  goal;
    logic [15:0] delay;
    logic        rev;
    logic        hdir;
  } lane_cmd_t;

  // What a lane reports towards the merge stage
  typedef struct packed {
    logic        fwd;
    logic        rvs;
    logic        homing;
    logic        busy;    // homing before this item
    logic        active;
    logic [31:0] pos;
  } lane_stat_t;

endpackage

/* hw/rtl/maepc_lane.sv */
// One axis: encoder unwrap, move regulation and homing
module maepc_lane #(
  parameter int COUNT_BITS = maepc_pkg::COUNT_BITS_DEF,
  parameter int WRAP_LIMIT = maepc_pkg::WRAP_LIMIT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  maepc_pkg::lane_cmd_t   cmd,
  input  maepc_pkg::lane_cfg_t   cfg,
  input  logic [COUNT_BITS-1:0]  raw,
  output maepc_pkg::lane_stat_t  stat
);
  import maepc_pkg::*;

  logic [31:0]           pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] prev_r;
  logic [9:0]            goal_r;
  logic [15:0]           wait_r, wait_nxt;
  logic                  act_r, act_nxt;
  logic                  hom_r, hom_nxt;
  logic                  seen_r, seen_nxt;
  logic [31:0]           ref_r, ref_nxt;
  logic [CNT_W-1:0]      hel_r, hel_nxt, idl_r, idl_nxt;
  logic                  fwd_r, fwd_nxt, rvs_r, rvs_nxt;

  logic signed [COUNT_BITS+1:0] dlt;
  logic [31:0]                  pos_upd, dif, mag;
  logic [25:0]                  prod;
  logic signed [33:0]           err;
  logic [33:0]                  emag;
  logic                         moved, done;

  // Unwrap the raw count difference
  always_comb begin
    dlt = $signed({2'b00, raw}) - $signed({2'b00, prev_r});
    if (dlt > $signed((COUNT_BITS+2)'(WRAP_LIMIT)))
      dlt = dlt - $signed((COUNT_BITS+2)'(1) <<< COUNT_BITS);
    else if (dlt < -$signed((COUNT_BITS+2)'(WRAP_LIMIT)))
      dlt = dlt + $signed((COUNT_BITS+2)'(1) <<< COUNT_BITS);
    pos_upd = pos_r + 32'($signed(dlt));
  end

  // Regulation error and homing motion test
  always_comb begin
    prod  = 26'(goal_r) * 26'(cfg.ppmm);
    err   = $signed({16'd0, prod[25:8]}) - $signed({{2{pos_upd[31]}}, pos_upd});
    emag  = err[33] ? 34'(-err) : 34'(err);
    dif   = pos_upd - ref_r;
    mag   = dif[31] ? (32'd0 - dif) : dif;
    moved = mag > 32'(cfg.stall_p);
  end

  // Next state
  always_comb begin
    pos_nxt = pos_r; wait_nxt = wait_r; act_nxt = act_r; hom_nxt = hom_r;
    seen_nxt = seen_r; ref_nxt = ref_r; hel_nxt = hel_r; idl_nxt = idl_r;
    fwd_nxt = fwd_r; rvs_nxt = rvs_r; done = 1'b0;
    if (cmd.tick) begin
      pos_nxt = pos_upd;
      if (hom_r) begin
        hel_nxt = (hel_r < CNT_MAX) ? hel_r + 1'b1 : hel_r;
        idl_nxt = (idl_r < CNT_MAX) ? idl_r + 1'b1 : idl_r;
        if (moved) begin
          seen_nxt = 1'b1; ref_nxt = pos_upd; idl_nxt = '0;
        end
        done = (hel_nxt >= cfg.max_t) || (!seen_nxt && hel_nxt >= cfg.grace)
            || (seen_nxt && idl_nxt >= cfg.stall_t);
        if (done) begin
          hom_nxt = 1'b0; fwd_nxt = 1'b0; rvs_nxt = 1'b0; pos_nxt = '0;
        end else begin
          fwd_nxt = cmd.hdir; rvs_nxt = !cmd.hdir;
        end
      end else if (act_r) begin
        if (wait_r != '0) wait_nxt = wait_r - 1'b1;
        if (wait_nxt == '0) begin
          if (emag <= 34'(cfg.deadband)) begin
            fwd_nxt = 1'b0; rvs_nxt = 1'b0;
          end else begin
            fwd_nxt = cmd.rev ? err[33] : !err[33];
            rvs_nxt = !fwd_nxt;
          end
        end
      end
    end else if (cmd.move) begin
      wait_nxt = cmd.delay; act_nxt = 1'b1;
    end else if (cmd.home) begin
      act_nxt = 1'b0; hom_nxt = 1'b1; seen_nxt = 1'b0; ref_nxt = pos_r;
      hel_nxt = '0; idl_nxt = '0; fwd_nxt = cmd.hdir; rvs_nxt = !cmd.hdir;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; prev_r <= '0; goal_r <= '0; wait_r <= '0; act_r <= 1'b0;
      hom_r <= 1'b0; seen_r <= 1'b0; ref_r <= '0; hel_r <= '0; idl_r <= '0;
      fwd_r <= 1'b0; rvs_r <= 1'b0;
    end else if (step) begin
      pos_r <= pos_nxt; wait_r <= wait_nxt; act_r <= act_nxt; hom_r <= hom_nxt;
      seen_r <= seen_nxt; ref_r <= ref_nxt; hel_r <= hel_nxt; idl_r <= idl_nxt;
      fwd_r <= fwd_nxt; rvs_r <= rvs_nxt;
      if (cmd.tick) prev_r <= raw;
      if (cmd.move) goal_r <= cmd.goal;
    end
  end

  // Lane report reflects state after this item; busy and pos show the state before it
  assign stat.fwd    = fwd_nxt;
  assign stat.rvs    = rvs_nxt;
  assign stat.homing = hom_nxt;
  assign stat.busy   = hom_r;
  assign stat.active = act_nxt;
  assign stat.pos    = pos_r;

endmodule

/* hw/rtl/multi_axis_encoder_position_control_top.sv */
// Top level: config registers, command decode, axis lanes and result merge
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | mode, axis, dest_mm, start_delay, enc_raw_a..d
//  out_    | output    | out_valid/out_stall | fwd_drive, rev_drive, status, masks, position
//  cfg_    | input     | cfg_we              | cfg_idx, cfg_wdata
// One item per cycle while in_stall is low; every lane updates in the cycle of the transfer and
// the result is held in a one-deep output register.
// rst_n is synchronous; all axis state clears to zero, registers to defaults.
// in_stall follows out_stall only while the output register is full.
module multi_axis_encoder_position_control_top #(
  parameter int AXES       = maepc_pkg::AXES_DEF,
  parameter int COUNT_BITS = maepc_pkg::COUNT_BITS_DEF,
  parameter int WRAP_LIMIT = maepc_pkg::WRAP_LIMIT_DEF,
  parameter int MAX_MM     = maepc_pkg::MAX_MM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_mode,
  input  logic [1:0]                          in_axis,
  input  logic [9:0]                          in_dest_mm,
  input  logic [15:0]                         in_start_delay,
  input  logic [15:0]                         in_enc_raw_a,
  input  logic [15:0]                         in_enc_raw_b,
  input  logic [15:0]                         in_enc_raw_c,
  input  logic [15:0]                         in_enc_raw_d,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [3:0]                          out_fwd_drive,
  output logic [3:0]                          out_rev_drive,
  output logic [1:0]                          out_status,
  output logic [3:0]                          out_homing_mask,
  output logic [3:0]                          out_active_mask,
  output logic signed [31:0]                  out_position,
  input  logic                                cfg_we,
  input  logic [maepc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [maepc_pkg::CFG_W-1:0]         cfg_wdata
);
  import maepc_pkg::*;

  lane_cfg_t   cfg_r;
  logic [3:0]  revm_r, homm_r;
  logic        step, ok;
  logic [1:0]  status;
  lane_cmd_t   cmd [AXES];
  lane_stat_t  st  [AXES];
  logic [15:0] raws [4];
  logic [3:0]  fwd_m, rev_m, hom_m, act_m;
  logic [31:0] rpos;
  logic        hom_sel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ppmm <= 16'd20462; cfg_r.deadband <= 10'd20; revm_r <= 4'hF;
      homm_r <= 4'hF; cfg_r.grace <= 17'd1200; cfg_r.stall_t <= 17'd1800;
      cfg_r.max_t <= 17'd70000; cfg_r.stall_p <= 8'd2;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_PPMM:     cfg_r.ppmm     <= cfg_wdata[15:0];
        REG_DEADBAND: cfg_r.deadband <= cfg_wdata[9:0];
        REG_REVERSE:  revm_r         <= cfg_wdata[3:0];
        REG_HOME_DIR: homm_r         <= cfg_wdata[3:0];
        REG_GRACE:    cfg_r.grace    <= cfg_wdata;
        REG_STALL_T:  cfg_r.stall_t  <= cfg_wdata;
        REG_MAX_T:    cfg_r.max_t    <= cfg_wdata;
        REG_STALL_P:  cfg_r.stall_p  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;
  assign raws[0] = in_enc_raw_a; assign raws[1] = in_enc_raw_b;
  assign raws[2] = in_enc_raw_c; assign raws[3] = in_enc_raw_d;

  // Lanes and per-lane command decode
  always_comb begin
    hom_sel = 1'b0;
    rpos    = '0;
    for (int a = 0; a < AXES; a++) begin
      if (32'(in_axis) == a) begin
        hom_sel = st[a].busy;
        rpos    = st[a].pos;
      end
    end
    status = ST_OK;
    ok     = 1'b0;
    if (32'(in_axis) < AXES) begin
      unique case (mode_t'(in_mode))
        MODE_MOVE: begin
          if (32'(in_dest_mm) > MAX_MM) status = ST_RANGE;
          else if (hom_sel)             status = ST_HOMING;
          else                          ok = 1'b1;
        end
        MODE_HOME: begin
          if (hom_sel) status = ST_HOMING;
          else         ok = 1'b1;
        end
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    logic [COUNT_BITS-1:0] lraw;
    if (a < 4) begin : g_enc
      assign lraw = COUNT_BITS'(raws[a]);
    end else begin : g_noenc
      // No encoder field: the count stays at zero, so the position never moves
      assign lraw = '0;
    end
    always_comb begin
      cmd[a].tick  = (mode_t'(in_mode) == MODE_TICK);
      cmd[a].move  = ok && (mode_t'(in_mode) == MODE_MOVE) && (32'(in_axis) == a);
      cmd[a].home  = ok && (mode_t'(in_mode) == MODE_HOME) && (32'(in_axis) == a);
      cmd[a].goal  = in_dest_mm;
      cmd[a].delay = in_start_delay;
      cmd[a].rev   = (a < 4) ? revm_r[a % 4] : 1'b0;
      cmd[a].hdir  = (a < 4) ? homm_r[a % 4] : 1'b0;
    end
    maepc_lane #(.COUNT_BITS(COUNT_BITS), .WRAP_LIMIT(WRAP_LIMIT)) u_lane (
      .clk(clk), .rst_n(rst_n), .step(step), .cmd(cmd[a]), .cfg(cfg_r),
      .raw(lraw), .stat(st[a])
    );
  end

  // Merge lane reports into the four-bit masks
  always_comb begin
    fwd_m = '0; rev_m = '0; hom_m = '0; act_m = '0;
    for (int a = 0; a < AXES && a < 4; a++) begin
      fwd_m[a] = st[a].fwd; rev_m[a] = st[a].rvs;
      hom_m[a] = st[a].homing; act_m[a] = st[a].active;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_fwd_drive   <= fwd_m;
      out_rev_drive   <= rev_m;
      out_status      <= status;
      out_homing_mask <= hom_m;
      out_active_mask <= act_m;
      out_position    <= (mode_t'(in_mode) == MODE_READ && 32'(in_axis) < AXES)
                         ? rpos : '0;
    end
  end

endmodule

/* tb/multi_axis_encoder_position_control_top_tb.sv */
// Testbench: random and directed transfers through the four-axis position controller, self-checked
module multi_axis_encoder_position_control_top_tb;
  import maepc_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int N_PHASES     = 7;
  localparam int PHASE_ITEMS  = 200;

  typedef struct {
    logic [3:0]  fwd;
    logic [3:0]  rvs;
    logic [1:0]  status;
    logic [3:0]  homing;
    logic [3:0]  active;
    logic [31:0] pos;
  } ctrl_result_t;

  // Expected results in order, compared against each output transfer
  class result_scoreboard;
    ctrl_result_t due_q[$];
    int errors;
    int checked;

    function void note_item(ctrl_result_t r);
      due_q.push_back(r);
    endfunction

    function void check_result(ctrl_result_t r);
      ctrl_result_t e;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: pos %0d", $signed(r.pos));
        return;
      end
      e = due_q.pop_front();
      checked++;
      if (e.fwd !== r.fwd || e.rvs !== r.rvs || e.status !== r.status ||
          e.homing !== r.homing || e.active !== r.active || e.pos !== r.pos) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: exp fwd %h rev %h st %0d hm %h am %h pos %0d, got fwd %h rev %h st %0d hm %h am %h pos %0d",
                   checked, e.fwd, e.rvs, e.status, e.homing, e.active, $signed(e.pos),
                   r.fwd, r.rvs, r.status, r.homing, r.active, $signed(r.pos));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_TICK;
  logic [1:0]  in_axis = '0;
  logic [9:0]  in_dest_mm = '0;
  logic [15:0] in_start_delay = '0;
  logic [15:0] in_enc_raw_a = '0, in_enc_raw_b = '0, in_enc_raw_c = '0, in_enc_raw_d = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_fwd_drive, out_rev_drive, out_homing_mask, out_active_mask;
  logic [1:0]  out_status;
  logic signed [31:0] out_position;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  multi_axis_encoder_position_control_top i_dut (.*);

  always #6 clk = ~clk;

  // Predictor state
  logic [15:0] r_ppmm;
  logic [9:0]  r_deadband;
  logic [3:0]  r_reverse, r_home_dir;
  logic [16:0] r_grace, r_stall_t, r_max_t;
  logic [7:0]  r_stall_p;
  logic [31:0] p_pos[4];
  logic [15:0] p_prev[4];
  logic [9:0]  p_goal[4];
  logic [15:0] p_wait[4];
  logic        p_active[4], p_homing[4], p_motion[4];
  logic [31:0] p_ref[4];
  logic [16:0] p_home_el[4], p_idle_el[4];
  logic [3:0]  p_fwd, p_rvs;

  result_scoreboard sb = new();
  int   cycles = 0;
  int   stall_left = 0;
  bit   rx_quiet = 0;
  int   n_items = 0, n_homes = 0, n_moves = 0;
  logic [15:0] raw_now[4];
  bit   stuck[4];

  function automatic void reset_model();
    r_ppmm = 16'd20462; r_deadband = 10'd20; r_reverse = 4'hF; r_home_dir = 4'hF;
    r_grace = 17'd1200; r_stall_t = 17'd1800; r_max_t = 17'd70000; r_stall_p = 8'd2;
    for (int a = 0; a < 4; a++) begin
      p_pos[a] = '0; p_prev[a] = '0; p_goal[a] = '0; p_wait[a] = '0;
      p_active[a] = 0; p_homing[a] = 0; p_motion[a] = 0; p_ref[a] = '0;
      p_home_el[a] = '0; p_idle_el[a] = '0;
    end
    p_fwd = '0; p_rvs = '0;
  endfunction

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_PPMM:     r_ppmm = v[15:0];
      REG_DEADBAND: r_deadband = v[9:0];
      REG_REVERSE:  r_reverse = v[3:0];
      REG_HOME_DIR: r_home_dir = v[3:0];
      REG_GRACE:    r_grace = v;
      REG_STALL_T:  r_stall_t = v;
      REG_MAX_T:    r_max_t = v;
      default:      r_stall_p = v[7:0];
    endcase
  endfunction

  // One controller step: returns what the block reports for the item
  function automatic ctrl_result_t control_step(logic [1:0] mode, logic [1:0] ax,
      logic [9:0] tmm, logic [15:0] dly, logic [15:0] raw[4]);
    ctrl_result_t r;
    int d;
    logic [31:0] diff, mag;
    longint tgt, err, emag;
    bit done, f;
    r.status = ST_OK;
    r.pos = '0;
    if (mode == MODE_TICK) begin
      for (int a = 0; a < 4; a++) begin
        d = int'(raw[a]) - int'(p_prev[a]);
        if (d > 30000) d -= 65536;
        else if (d < -30000) d += 65536;
        p_pos[a] += 32'(d);
        p_prev[a] = raw[a];
        if (p_homing[a]) begin
          diff = p_pos[a] - p_ref[a];
          mag = diff[31] ? -diff : diff;
          if (p_home_el[a] != CNT_MAX) p_home_el[a]++;
          if (p_idle_el[a] != CNT_MAX) p_idle_el[a]++;
          if (mag > r_stall_p) begin
            p_motion[a] = 1; p_ref[a] = p_pos[a]; p_idle_el[a] = '0;
          end
          done = p_home_el[a] >= r_max_t || (!p_motion[a] && p_home_el[a] >= r_grace) ||
                 (p_motion[a] && p_idle_el[a] >= r_stall_t);
          if (done) begin
            p_homing[a] = 0; p_fwd[a] = 0; p_rvs[a] = 0; p_pos[a] = '0;
          end else begin
            p_fwd[a] = r_home_dir[a]; p_rvs[a] = ~r_home_dir[a];
          end
        end else if (p_active[a]) begin
          if (p_wait[a] != 0) p_wait[a]--;
          if (p_wait[a] == 0) begin
            tgt = (longint'(p_goal[a]) * longint'(r_ppmm)) >>> 8;
            err = tgt - longint'($signed(p_pos[a]));
            emag = err < 0 ? -err : err;
            if (emag <= longint'(r_deadband)) begin
              p_fwd[a] = 0; p_rvs[a] = 0;
            end else begin
              f = r_reverse[a] ? (err < 0) : (err > 0);
              p_fwd[a] = f; p_rvs[a] = !f;
            end
          end
        end
      end
    end else if (mode == MODE_MOVE) begin
      if (tmm > 10'd600) r.status = ST_RANGE;
      else if (p_homing[ax]) r.status = ST_HOMING;
      else begin
        p_goal[ax] = tmm; p_wait[ax] = dly; p_active[ax] = 1;
      end
    end else if (mode == MODE_HOME) begin
      if (p_homing[ax]) r.status = ST_HOMING;
      else begin
        p_active[ax] = 0; p_homing[ax] = 1; p_motion[ax] = 0; p_ref[ax] = p_pos[ax];
        p_home_el[ax] = '0; p_idle_el[ax] = '0;
        p_fwd[ax] = r_home_dir[ax]; p_rvs[ax] = ~r_home_dir[ax];
      end
    end else begin
      r.pos = p_pos[ax];
    end
    r.fwd = p_fwd;
    r.rvs = p_rvs;
    for (int a = 0; a < 4; a++) begin
      r.homing[a] = p_homing[a];
      r.active[a] = p_active[a];
    end
    return r;
  endfunction

  // Watch both channels and the register port at each rising edge
  always @(posedge clk) begin
    ctrl_result_t got;
    logic [15:0] raws[4];
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("multi_axis_encoder_position_control_top: mismatch");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.fwd = out_fwd_drive; got.rvs = out_rev_drive; got.status = out_status;
        got.homing = out_homing_mask; got.active = out_active_mask; got.pos = out_position;
        sb.check_result(got);
        stall_left = rx_quiet ? 0 : $urandom_range(0, 14);
      end
      if (cfg_we) write_reg(cfg_idx, cfg_wdata);
      if (in_valid && !in_stall) begin
        raws[0] = in_enc_raw_a; raws[1] = in_enc_raw_b;
        raws[2] = in_enc_raw_c; raws[3] = in_enc_raw_d;
        sb.note_item(control_step(in_mode, in_axis, in_dest_mm, in_start_delay, raws));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Drive one input transfer after a gap, hold until accepted
  task automatic send_item(logic [1:0] mode, logic [1:0] ax, logic [9:0] tmm,
                           logic [15:0] dly, int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode = mode; in_axis = ax; in_dest_mm = tmm; in_start_delay = dly;
    in_enc_raw_a = raw_now[0]; in_enc_raw_b = raw_now[1];
    in_enc_raw_c = raw_now[2]; in_enc_raw_d = raw_now[3];
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we = 1'b1; cfg_idx = idx; cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Encoders follow the drive pins, with stuck axes, noise and wild jumps
  task automatic move_plant();
    int v;
    for (int a = 0; a < 4; a++) begin
      if ($urandom_range(0, 49) == 0) stuck[a] = !stuck[a];
      v = $urandom_range(0, 400);
      if (r_reverse[a]) v = -v;
      if ($urandom_range(0, 19) == 0) raw_now[a] = 16'($urandom());
      else if (!stuck[a] && p_fwd[a]) raw_now[a] = raw_now[a] + 16'(v);
      else if (!stuck[a] && p_rvs[a]) raw_now[a] = raw_now[a] - 16'(v);
      else raw_now[a] = raw_now[a] + 16'($urandom_range(0, 4)) - 16'd2;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] cv[8];
    int gap, pick;
    bit tx_quiet;
    logic [9:0] tmm;
    logic [15:0] dly;
    reset_model();
    for (int a = 0; a < 4; a++) begin
      raw_now[a] = '0; stuck[a] = 0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: wrap, ranges, delays and homing clashes
    send_item(MODE_READ, 2'd0, '0, '0, 0);
    raw_now = '{16'hFFFF, 16'h7531, 16'd30000, 16'h8000};
    send_item(MODE_TICK, 2'd0, '0, '0, 0);
    raw_now = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000};
    send_item(MODE_TICK, 2'd0, '0, '0, 0);
    send_item(MODE_MOVE, 2'd0, 10'd1023, 16'd0, 0);
    send_item(MODE_MOVE, 2'd1, 10'd601, 16'd0, 0);
    send_item(MODE_MOVE, 2'd0, 10'd600, 16'd0, 0);
    send_item(MODE_MOVE, 2'd1, 10'd0, 16'hFFFF, 0);
    send_item(MODE_MOVE, 2'd3, 10'd1, 16'd1, 0);
    send_item(MODE_HOME, 2'd2, '0, '0, 0);
    send_item(MODE_MOVE, 2'd2, 10'd5, 16'd0, 0);
    send_item(MODE_HOME, 2'd2, '0, '0, 0);
    send_item(MODE_READ, 2'd2, '0, '0, 0);
    send_item(MODE_TICK, 2'd0, '0, '0, 0);
    send_item(MODE_TICK, 2'd0, '0, '0, 0);
    for (int a = 0; a < 4; a++) send_item(MODE_READ, a[1:0], '0, '0, 0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        for (int i = 0; i < 8; i++) begin
          if (ph == 1) cv[i] = '0;
          else if (ph == 2) cv[i] = '1;
          else case (i)
            REG_PPMM:     cv[i] = CFG_W'($urandom_range(0, 65535));
            REG_DEADBAND: cv[i] = CFG_W'($urandom_range(0, 1023));
            REG_REVERSE, REG_HOME_DIR: cv[i] = CFG_W'($urandom_range(0, 15));
            REG_GRACE, REG_STALL_T: cv[i] = CFG_W'($urandom_range(1, 60));
            REG_MAX_T:    cv[i] = CFG_W'($urandom_range(20, 400));
            default:      cv[i] = CFG_W'($urandom_range(0, 20));
          endcase
          cfg_write(i[CFG_IDX_W-1:0], cv[i]);
        end
      end
      tx_quiet = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        // Let everything drain once per phase before carrying on
        if (k == PHASE_ITEMS / 2) wait_drained();
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          move_plant();
          send_item(MODE_TICK, 2'($urandom_range(0, 3)), 10'($urandom()),
                    16'($urandom()), gap);
        end else if (pick < 75) begin
          tmm = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(601, 1023))
                                            : 10'($urandom_range(0, 600));
          dly = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20));
          n_moves++;
          send_item(MODE_MOVE, 2'($urandom_range(0, 3)), tmm, dly, gap);
        end else if (pick < 85) begin
          n_homes++;
          send_item(MODE_HOME, 2'($urandom_range(0, 3)), 10'($urandom()),
                    16'($urandom()), gap);
        end else begin
          send_item(MODE_READ, 2'($urandom_range(0, 3)), 10'($urandom()),
                    16'($urandom()), gap);
        end
      end
    end

    in_valid = 1'b0;
    rx_quiet = 1;
    while (sb.due_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Ran %0d transfers (%0d moves, %0d homes) over %0d register settings,",
             n_items, n_moves, n_homes, N_PHASES);
    $display("with random gaps and back-pressure; %0d results checked, %0d wrong.",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("multi_axis_encoder_position_control_top: match");
    end else begin
      $display("multi_axis_encoder_position_control_top: mismatch");
    end
    $finish;
  end

endmodule

/* multi_axis_encoder_position_control_top.f */
hw/rtl/maepc_pkg.sv
hw/rtl/maepc_lane.sv
hw/rtl/multi_axis_encoder_position_control_top.sv
tb/multi_axis_encoder_position_control_top_tb.sv
